### src/rgbhsv_pkg.sv
// Shared constants for the RGB to HSV pixel converter.
// No dependencies.
`default_nettype none
package rgbhsv_pkg;
   localparam int CHANNEL_BITS_DEF  = 8;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int QUEUE_DEPTH       = 4;
endpackage
`default_nettype wire

### src/rgbhsv_front.sv
// Front stage: max, min, chroma, hue sector numerator and divisors.
// Depends on rgbhsv_pkg.
`default_nettype none
module rgbhsv_front #(
   parameter int CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [CHANNEL_BITS-1:0] req_red,
   input  wire logic [CHANNEL_BITS-1:0] req_green,
   input  wire logic [CHANNEL_BITS-1:0] req_blue,
   output logic                         cls_valid,
   input  wire logic                    cls_stall,
   output logic [CHANNEL_BITS-1:0]      cls_value,
   output logic [CHANNEL_BITS-1:0]      cls_chroma,
   output logic [CHANNEL_BITS+2:0]      cls_num,
   output logic [CHANNEL_BITS+2:0]      cls_den
);
   import rgbhsv_pkg::*;
   localparam int C = CHANNEL_BITS;

   logic          valid_ff;
   logic [C-1:0]  value_ff, value_in, chroma_ff, chroma_in, lo;
   logic [C+2:0]  num_ff, num_in, den_ff, den_in;
   logic signed [C+3:0] n, c2, c4, c6;

   always_comb begin
      value_in = req_red;
      if (req_green > value_in) value_in = req_green;
      if (req_blue > value_in) value_in = req_blue;
      lo = req_red;
      if (req_green < lo) lo = req_green;
      if (req_blue < lo) lo = req_blue;
      chroma_in = value_in - lo;
      c2 = $signed({3'b000, chroma_in, 1'b0});
      c4 = $signed({2'b00, chroma_in, 2'b00});
      c6 = c2 + c4;
      priority if (value_in == req_red) begin
         n = $signed({4'b0000, req_green}) - $signed({4'b0000, req_blue});
      end else if (value_in == req_green) begin
         n = c2 + $signed({4'b0000, req_blue}) - $signed({4'b0000, req_red});
      end else begin
         n = c4 + $signed({4'b0000, req_red}) - $signed({4'b0000, req_green});
      end
      if (n < 0) n = n + c6;
      num_in = n[C+2:0];
      den_in = c6[C+2:0];
   end

   assign req_stall = valid_ff && cls_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
      if (!req_stall) begin
         value_ff  <= value_in;
         chroma_ff <= chroma_in;
         num_ff    <= num_in;
         den_ff    <= den_in;
      end
   end

   assign cls_valid  = valid_ff;
   assign cls_value  = value_ff;
   assign cls_chroma = chroma_ff;
   assign cls_num    = num_ff;
   assign cls_den    = den_ff;
endmodule
`default_nettype wire

### src/rgbhsv_queue.sv
// Short FIFO between front and back stages.
// Depends on rgbhsv_pkg.
`default_nettype none
module rgbhsv_queue #(
   parameter int DATA_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   output logic                      push_stall,
   input  wire logic [DATA_BITS-1:0] push_data,
   output logic                      pop_valid,
   input  wire logic                 pop_stall,
   output logic [DATA_BITS-1:0]      pop_data
);
   import rgbhsv_pkg::*;
   localparam int PW = $clog2(QUEUE_DEPTH);

   logic [DATA_BITS-1:0] mem_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]   cnt_ff, cnt_in;
   logic push, pop;

   assign push_stall = (cnt_ff == (PW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign push = push_valid && !push_stall;
   assign pop  = pop_valid && !pop_stall;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + PW'(1) : wr_ff;
      rd_in  = pop ? rd_ff + PW'(1) : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end
endmodule
`default_nettype wire

### src/rgbhsv_back.sv
// Back stage: two pipelined restoring dividers, one quotient bit per stage.
// Depends on rgbhsv_pkg.
`default_nettype none
module rgbhsv_back #(
   parameter int CHANNEL_BITS  = rgbhsv_pkg::CHANNEL_BITS_DEF,
   parameter int FRACTION_BITS = rgbhsv_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_stall,
   input  wire logic [CHANNEL_BITS-1:0]  in_value,
   input  wire logic [CHANNEL_BITS-1:0]  in_chroma,
   input  wire logic [CHANNEL_BITS+2:0]  in_num,
   input  wire logic [CHANNEL_BITS+2:0]  in_den,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [FRACTION_BITS-1:0]      rsp_hue,
   output logic [FRACTION_BITS:0]        rsp_saturation,
   output logic [CHANNEL_BITS-1:0]       rsp_value
);
   import rgbhsv_pkg::*;
   localparam int C = CHANNEL_BITS;
   localparam int F = FRACTION_BITS;
   localparam int S = F + 1;
   localparam int H = C + 3;

   logic         valid_ff [S];
   logic [C-1:0] sr_ff [S], sr_in [S], sd_ff [S], sd_in [S];
   logic [H-1:0] hr_ff [S], hr_in [S], hd_ff [S], hd_in [S];
   logic [F:0]   sq_ff [S], sq_in [S], hq_ff [S], hq_in [S];
   logic         advance;

   assign advance  = !(valid_ff[S-1] && rsp_stall);
   assign in_stall = !advance;

   always_comb begin
      logic        ge;
      logic [C:0]  ssh;
      logic [H:0]  hsh;
      ge = (in_chroma >= in_value);
      sd_in[0] = in_value;
      sr_in[0] = ge ? in_chroma - in_value : in_chroma;
      sq_in[0] = (F+1)'(ge);
      ge = (in_num >= in_den);
      hd_in[0] = in_den;
      hr_in[0] = ge ? in_num - in_den : in_num;
      hq_in[0] = (F+1)'(ge);
      for (int k = 1; k < S; k++) begin
         ssh = {sr_ff[k-1], 1'b0};
         ge  = (ssh >= {1'b0, sd_ff[k-1]});
         sd_in[k] = sd_ff[k-1];
         sr_in[k] = ge ? C'(ssh - {1'b0, sd_ff[k-1]}) : C'(ssh);
         sq_in[k] = {sq_ff[k-1][F-1:0], ge};
         hsh = {hr_ff[k-1], 1'b0};
         ge  = (hsh >= {1'b0, hd_ff[k-1]});
         hd_in[k] = hd_ff[k-1];
         hr_in[k] = ge ? H'(hsh - {1'b0, hd_ff[k-1]}) : H'(hsh);
         hq_in[k] = {hq_ff[k-1][F-1:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < S; k++) valid_ff[k] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < S; k++) valid_ff[k] <= valid_ff[k-1];
      end
      if (advance) begin
         for (int k = 0; k < S; k++) begin
            sr_ff[k] <= sr_in[k];
            sd_ff[k] <= sd_in[k];
            sq_ff[k] <= sq_in[k];
            hr_ff[k] <= hr_in[k];
            hd_ff[k] <= hd_in[k];
            hq_ff[k] <= hq_in[k];
         end
      end
   end

   // zero divisor: black pixel or gray pixel
   assign rsp_valid      = valid_ff[S-1];
   assign rsp_value      = sd_ff[S-1];
   assign rsp_saturation = (sd_ff[S-1] == '0) ? '0 : sq_ff[S-1];
   assign rsp_hue        = (hd_ff[S-1] == '0) ? '0 : hq_ff[S-1][F-1:0];
endmodule
`default_nettype wire

### src/rgb_to_hsv_pixel_top.sv
// Top level of the RGB to HSV pixel converter.
// Depends on rgbhsv_pkg, rgbhsv_front, rgbhsv_queue, rgbhsv_back.
//
// Usage:
//   req_ channel: one RGB pixel per beat (req_red, req_green, req_blue).
//   rsp_ channel: one HSV result per beat (rsp_hue, rsp_saturation, rsp_value),
//   in pixel order. A beat moves when valid is high and stall is low.
//   Throughput: one pixel per cycle while rsp_stall is low, set by the fully pipelined dividers.
//   Path with an empty queue: 1 front register, then the queue memory, then
//   FRACTION_BITS + 1 divider stages.
//   Receiver stall freezes the divider pipeline; the queue (4 beats) then
//   fills and req_stall rises once queue and front register are full.
//   Reset (synchronous) empties the pipeline, queue and front register.
//   Saturation 2^FRACTION_BITS means exactly one.
`default_nettype none
module rgb_to_hsv_pixel_top #(
   parameter int CHANNEL_BITS  = rgbhsv_pkg::CHANNEL_BITS_DEF,
   parameter int FRACTION_BITS = rgbhsv_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [CHANNEL_BITS-1:0]  req_red,
   input  wire logic [CHANNEL_BITS-1:0]  req_green,
   input  wire logic [CHANNEL_BITS-1:0]  req_blue,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [FRACTION_BITS-1:0]      rsp_hue,
   output logic [FRACTION_BITS:0]        rsp_saturation,
   output logic [CHANNEL_BITS-1:0]       rsp_value
);
   import rgbhsv_pkg::*;
   localparam int C  = CHANNEL_BITS;
   localparam int DW = 2 * C + 2 * (C + 3);

   logic          cls_valid, cls_stall, q_valid, q_stall;
   logic [C-1:0]  cls_value, cls_chroma, q_value, q_chroma;
   logic [C+2:0]  cls_num, cls_den, q_num, q_den;
   logic [DW-1:0] q_data;

   rgbhsv_front #(.CHANNEL_BITS(C)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_red, .req_green, .req_blue,
      .cls_valid, .cls_stall, .cls_value, .cls_chroma, .cls_num, .cls_den
   );

   rgbhsv_queue #(.DATA_BITS(DW)) u_queue (
      .clock, .reset,
      .push_valid(cls_valid), .push_stall(cls_stall),
      .push_data({cls_value, cls_chroma, cls_num, cls_den}),
      .pop_valid(q_valid), .pop_stall(q_stall), .pop_data(q_data)
   );

   assign {q_value, q_chroma, q_num, q_den} = q_data;

   rgbhsv_back #(.CHANNEL_BITS(C), .FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_stall(q_stall),
      .in_value(q_value), .in_chroma(q_chroma), .in_num(q_num), .in_den(q_den),
      .rsp_valid, .rsp_stall, .rsp_hue, .rsp_saturation, .rsp_value
   );

   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_saturation <= (FRACTION_BITS+1)'(1) << FRACTION_BITS))
      else $error("saturation above one");

   a_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_value == '0) |-> (rsp_saturation == '0 && rsp_hue == '0))
      else $error("black pixel with nonzero hue or saturation");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");
endmodule
`default_nettype wire
